[hw/rtl/sss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants of the state-space step evaluator
// Field widths, command word between the front end and the engine, engine
// states and the saturation bounds used by the result stage.
// ----------------------------------------------------------------------------
package sss_pkg;

    // Widths fixed by the item fields.
    localparam int VAL_W            = 16;
    localparam int NUM_STATE_FIELDS = 4;
    localparam int NUM_DRIVE_FIELDS = 2;
    localparam int NUM_PRED_FIELDS  = 2;
    localparam int NUM_RESULTS      = NUM_STATE_FIELDS + NUM_PRED_FIELDS;
    localparam int IDX_W            = 2;
    localparam int DRV_IDX_W        = $clog2(NUM_DRIVE_FIELDS);
    localparam int DEST_W           = $clog2(NUM_RESULTS);
    localparam int NS_W             = 3;
    localparam int ND_W             = 2;
    localparam int NO_W             = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 3;

    // Datapath widths: a 16x16 product and a sum of up to six of them.
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + 4;

    // Saturation bounds of a 16-bit signed result, at accumulator width.
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

    // Command queue between front end and engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        MAT_A = 2'd0,
        MAT_B = 2'd1,
        MAT_C = 2'd2,
        MAT_D = 2'd3
    } matrix_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATE_COUNT  = 2'd0,
        CFG_DRIVE_COUNT  = 2'd1,
        CFG_OUTPUT_COUNT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ENG_CLEAR,
        ENG_IDLE,
        ENG_ISSUE,
        ENG_DRAIN
    } eng_state_t;

    // One classified word as it travels from the front end to the engine.
    typedef struct packed {
        logic                                       is_eval;
        logic                                       load_ok;
        matrix_t                                    matrix;
        logic [IDX_W-1:0]                           row;
        logic [IDX_W-1:0]                           col;
        logic [VAL_W-1:0]                           value;
        logic [NUM_STATE_FIELDS-1:0][VAL_W-1:0]     state;
        logic [NUM_DRIVE_FIELDS-1:0][VAL_W-1:0]     drive;
        logic [NS_W-1:0]                            ns;
        logic [ND_W-1:0]                            nd;
        logic [NO_W-1:0]                            no;
    } cmd_t;

endpackage

[hw/rtl/sss_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_front: input front end
// Holds the count registers, accepts input words, checks load coordinates
// against the matrix bounds and pushes classified commands into the queue.
// ----------------------------------------------------------------------------
module sss_front
    import sss_pkg::*;
#(
    parameter int MAX_STATES  = 4,
    parameter int MAX_DRIVES  = 2,
    parameter int MAX_OUTPUTS = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [1:0]              coef_matrix,
    input  logic [IDX_W-1:0]        coef_row,
    input  logic [IDX_W-1:0]        coef_col,
    input  logic signed [VAL_W-1:0] coef_value,
    input  logic signed [VAL_W-1:0] state_0,
    input  logic signed [VAL_W-1:0] state_1,
    input  logic signed [VAL_W-1:0] state_2,
    input  logic signed [VAL_W-1:0] state_3,
    input  logic signed [VAL_W-1:0] drive_0,
    input  logic signed [VAL_W-1:0] drive_1,
    input  logic                    clearing,
    input  logic                    q_full,
    output logic                    push,
    output cmd_t                    push_cmd
);

    // Effective count caps: parameter maximum and number of carried fields.
    localparam int NS_CAP = (MAX_STATES < NUM_STATE_FIELDS) ? MAX_STATES : NUM_STATE_FIELDS;
    localparam int ND_CAP = (MAX_DRIVES < NUM_DRIVE_FIELDS) ? MAX_DRIVES : NUM_DRIVE_FIELDS;
    localparam int NO_CAP = (MAX_OUTPUTS < NUM_PRED_FIELDS) ? MAX_OUTPUTS : NUM_PRED_FIELDS;

    logic [NS_W-1:0] state_count_reg;
    logic [ND_W-1:0] drive_count_reg;
    logic [NO_W-1:0] output_count_reg;
    logic [NS_W-1:0] ns_eff;
    logic [ND_W-1:0] nd_eff;
    logic [NO_W-1:0] no_eff;
    logic            row_in_states;
    logic            row_in_outputs;
    logic            col_in_states;
    logic            col_in_drives;
    logic            load_ok;

    // Count registers; writes to an index beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg  <= NS_W'(4);
            drive_count_reg  <= ND_W'(1);
            output_count_reg <= NO_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STATE_COUNT:  state_count_reg  <= cfg_data;
                CFG_DRIVE_COUNT:  drive_count_reg  <= cfg_data[ND_W-1:0];
                CFG_OUTPUT_COUNT: output_count_reg <= cfg_data[NO_W-1:0];
                default:          ;
            endcase
        end
    end

    // Counts above the cap act as the cap.
    always_comb
    begin
        ns_eff = (int'(state_count_reg) > NS_CAP) ? NS_W'(NS_CAP) : state_count_reg;
        nd_eff = (int'(drive_count_reg) > ND_CAP) ? ND_W'(ND_CAP) : drive_count_reg;
        no_eff = (int'(output_count_reg) > NO_CAP) ? NO_W'(NO_CAP) : output_count_reg;
    end

    // A load outside its matrix at full size is dropped by the engine.
    always_comb
    begin
        row_in_states  = int'(coef_row) < MAX_STATES;
        row_in_outputs = int'(coef_row) < MAX_OUTPUTS;
        col_in_states  = int'(coef_col) < MAX_STATES;
        col_in_drives  = int'(coef_col) < MAX_DRIVES;
        unique case (matrix_t'(coef_matrix))
            MAT_A:   load_ok = row_in_states && col_in_states;
            MAT_B:   load_ok = row_in_states && col_in_drives;
            MAT_C:   load_ok = row_in_outputs && col_in_states;
            MAT_D:   load_ok = row_in_outputs && col_in_drives;
            default: load_ok = 1'b0;
        endcase
    end

    // Accept while the queue has room and the store sweep is over.
    assign in_ready = !q_full && !clearing;
    assign push     = in_valid && in_ready;

    // Classified command word.
    always_comb
    begin
        push_cmd          = '0;
        push_cmd.is_eval  = (req_t'(req_type) == REQ_EVAL);
        push_cmd.load_ok  = load_ok;
        push_cmd.matrix   = matrix_t'(coef_matrix);
        push_cmd.row      = coef_row;
        push_cmd.col      = coef_col;
        push_cmd.value    = coef_value;
        push_cmd.state[0] = state_0;
        push_cmd.state[1] = state_1;
        push_cmd.state[2] = state_2;
        push_cmd.state[3] = state_3;
        push_cmd.drive[0] = drive_0;
        push_cmd.drive[1] = drive_1;
        push_cmd.ns       = ns_eff;
        push_cmd.nd       = nd_eff;
        push_cmd.no       = no_eff;
    end

endmodule

[hw/rtl/sss_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_queue: command queue
// Short first-in first-out buffer that decouples the front end from the
// engine, so either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module sss_queue
    import sss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic q_full,
    output logic q_empty
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];

    // Pointer and fill count update, with explicit wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/sss_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_engine: coefficient store and multiply-accumulate engine
// Clears the coefficient memory after reset, executes loads, and walks one
// coefficient per cycle through a shared multiply-accumulate pipeline for
// each evaluate command. Results are held in the output register.
// ----------------------------------------------------------------------------
module sss_engine
    import sss_pkg::*;
#(
    parameter int MAX_STATES  = 4,
    parameter int MAX_DRIVES  = 2,
    parameter int MAX_OUTPUTS = 2,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  cmd_t                                head,
    output logic                                pop,
    output logic                                clearing,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [NUM_RESULTS-1:0][VAL_W-1:0]   result,
    output logic                                saturated
);

    // Store layout: A, B, C, D, each row major.
    localparam int BASE_A      = 0;
    localparam int BASE_B      = BASE_A + MAX_STATES * MAX_STATES;
    localparam int BASE_C      = BASE_B + MAX_STATES * MAX_DRIVES;
    localparam int BASE_D      = BASE_C + MAX_OUTPUTS * MAX_STATES;
    localparam int STORE_DEPTH = BASE_D + MAX_OUTPUTS * MAX_DRIVES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    typedef struct packed {
        logic              first;
        logic              last;
        logic [DEST_W-1:0] dest;
    } tag_t;

    function automatic logic [ADDR_W-1:0] coef_addr(input matrix_t mat,
                                                    input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        int base;
        int cols;
        unique case (mat)
            MAT_A:   begin base = BASE_A; cols = MAX_STATES; end
            MAT_B:   begin base = BASE_B; cols = MAX_DRIVES; end
            MAT_C:   begin base = BASE_C; cols = MAX_STATES; end
            default: begin base = BASE_D; cols = MAX_DRIVES; end
        endcase
        return ADDR_W'(base + int'(r) * cols + int'(c));
    endfunction

    logic signed [VAL_W-1:0]    coef_mem [STORE_DEPTH];

    eng_state_t                 state_reg;
    eng_state_t                 state_next;
    logic [ADDR_W-1:0]          clr_cnt_reg;

    // Walk position: row group, row, term phase (state or drive), column.
    logic                       grp_reg;
    logic                       grp_next;
    logic [IDX_W-1:0]           row_reg;
    logic [IDX_W-1:0]           row_next;
    logic                       phase_reg;
    logic                       phase_next;
    logic [IDX_W-1:0]           col_reg;
    logic [IDX_W-1:0]           col_next;

    logic signed [VAL_W-1:0]    x_reg [NUM_STATE_FIELDS];
    logic signed [VAL_W-1:0]    u_reg [NUM_DRIVE_FIELDS];
    logic [NS_W-1:0]            ns_reg;
    logic [ND_W-1:0]            nd_reg;
    logic [NO_W-1:0]            no_reg;

    // Pipeline: memory read, multiply, accumulate, saturate.
    logic                       s1_v_reg;
    tag_t                       s1_tag_reg;
    logic signed [VAL_W-1:0]    rd_data_reg;
    logic signed [VAL_W-1:0]    op_reg;
    logic                       s2_v_reg;
    tag_t                       s2_tag_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       fin_reg;
    logic [DEST_W-1:0]          s3_dest_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    prod_ext;

    logic [NUM_RESULTS-1:0][VAL_W-1:0] res_reg;
    logic                       sat_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    logic                       pop_eval;
    logic                       has_work;
    logic                       issue;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic signed [VAL_W-1:0]    wr_data;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [VAL_W-1:0]    operand;
    tag_t                       tag;
    logic [NS_W-1:0]            term_lim;
    logic [NS_W-1:0]            row_lim;
    logic                       last_in_phase;
    logic                       row_end;
    logic                       last_row;
    logic                       walk_end;
    logic                       pipe_empty;
    logic signed [ACC_W-1:0]    shifted;
    logic [VAL_W-1:0]           sat_val;
    logic                       clip;

    // Evaluate commands start only when the output register is free.
    assign has_work   = (head.ns != '0) || ((head.no != '0) && (head.nd != '0));
    assign pipe_empty = !s1_v_reg && !s2_v_reg && !fin_reg;

    // Walk bookkeeping for the current term.
    always_comb
    begin
        term_lim      = phase_reg ? NS_W'(nd_reg) : ns_reg;
        row_lim       = grp_reg ? NS_W'(no_reg) : ns_reg;
        last_in_phase = ({1'b0, col_reg} == term_lim - 1'b1);
        row_end       = last_in_phase && (phase_reg || (nd_reg == '0));
        last_row      = ({1'b0, row_reg} == row_lim - 1'b1);
        walk_end      = issue && row_end && last_row && (grp_reg || (no_reg == '0));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ENG_IDLE;
                end
            end
            ENG_IDLE:
            begin
                if (pop_eval && has_work)
                begin
                    state_next = ENG_ISSUE;
                end
            end
            ENG_ISSUE:
            begin
                if (walk_end)
                begin
                    state_next = ENG_DRAIN;
                end
            end
            ENG_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default: state_next = ENG_CLEAR;
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        clearing = (state_reg == ENG_CLEAR);
        issue    = (state_reg == ENG_ISSUE);
        pop      = (state_reg == ENG_IDLE) && !q_empty && (!head.is_eval || !out_valid_reg);
        pop_eval = pop && head.is_eval;
        wr_en    = clearing || (pop && !head.is_eval && head.load_ok);
        wr_addr  = clearing ? clr_cnt_reg : coef_addr(head.matrix, head.row, head.col);
        wr_data  = clearing ? '0 : $signed(head.value);
    end

    // Walk position advance: columns, then drive terms, then rows, then group.
    always_comb
    begin
        grp_next   = grp_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        col_next   = col_reg;
        if (pop_eval)
        begin
            grp_next   = (head.ns == '0);
            row_next   = '0;
            phase_next = (head.ns == '0);
            col_next   = '0;
        end
        else if (issue)
        begin
            if (!last_in_phase)
            begin
                col_next = col_reg + 1'b1;
            end
            else if (!row_end)
            begin
                phase_next = 1'b1;
                col_next   = '0;
            end
            else if (!last_row)
            begin
                row_next   = row_reg + 1'b1;
                phase_next = (ns_reg == '0);
                col_next   = '0;
            end
            else if (!grp_reg && (no_reg != '0))
            begin
                grp_next   = 1'b1;
                row_next   = '0;
                phase_next = 1'b0;
                col_next   = '0;
            end
        end
    end

    // Coefficient address, operand and tag of the term being issued.
    always_comb
    begin
        if (phase_reg)
        begin
            rd_addr = coef_addr(grp_reg ? MAT_D : MAT_B, row_reg, col_reg);
            operand = u_reg[col_reg[DRV_IDX_W-1:0]];
        end
        else
        begin
            rd_addr = coef_addr(grp_reg ? MAT_C : MAT_A, row_reg, col_reg);
            operand = x_reg[col_reg];
        end
        tag.first = (col_reg == '0) && (!phase_reg || (ns_reg == '0));
        tag.last  = row_end;
        tag.dest  = grp_reg ? DEST_W'(NUM_STATE_FIELDS + int'(row_reg)) : DEST_W'(row_reg);
    end

    // Output valid: set at the end of a walk or for an evaluate with nothing to compute, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((pop_eval && !has_work) || ((state_reg == ENG_DRAIN) && pipe_empty))
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_CLEAR;
            clr_cnt_reg   <= '0;
            grp_reg       <= 1'b0;
            row_reg       <= '0;
            phase_reg     <= 1'b0;
            col_reg       <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
            grp_reg       <= grp_next;
            row_reg       <= row_next;
            phase_reg     <= phase_next;
            col_reg       <= col_next;
            s1_v_reg      <= issue;
            s2_v_reg      <= s1_v_reg;
            fin_reg       <= s2_v_reg && s2_tag_reg.last;
            out_valid_reg <= out_valid_next;
        end
    end

    // Coefficient memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coef_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= coef_mem[rd_addr];
    end

    // Operands captured when an evaluate command starts.
    always_ff @(posedge clk)
    begin
        if (pop_eval)
        begin
            for (int i = 0; i < NUM_STATE_FIELDS; i++)
            begin
                x_reg[i] <= $signed(head.state[i]);
            end
            for (int i = 0; i < NUM_DRIVE_FIELDS; i++)
            begin
                u_reg[i] <= $signed(head.drive[i]);
            end
            ns_reg <= head.ns;
            nd_reg <= head.nd;
            no_reg <= head.no;
        end
    end

    // Multiply-accumulate datapath.
    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk)
    begin
        s1_tag_reg  <= tag;
        op_reg      <= operand;
        s2_tag_reg  <= s1_tag_reg;
        prod_reg    <= rd_data_reg * op_reg;
        s3_dest_reg <= s2_tag_reg.dest;
        if (s2_v_reg)
        begin
            acc_reg <= s2_tag_reg.first ? prod_ext : acc_reg + prod_ext;
        end
    end

    // Scale by an arithmetic shift (rounds toward minus infinity), then clip.
    always_comb
    begin
        shifted = acc_reg >>> FRAC_BITS;
        clip    = 1'b0;
        sat_val = shifted[VAL_W-1:0];
        if (shifted > SAT_MAX)
        begin
            sat_val = SAT_MAX[VAL_W-1:0];
            clip    = 1'b1;
        end
        else if (shifted < SAT_MIN)
        begin
            sat_val = SAT_MIN[VAL_W-1:0];
            clip    = 1'b1;
        end
    end

    // Result register: cleared at the start, filled one row at a time.
    always_ff @(posedge clk)
    begin
        if (pop_eval)
        begin
            res_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (fin_reg)
        begin
            res_reg[s3_dest_reg] <= sat_val;
            sat_reg              <= sat_reg | clip;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;
    assign saturated = sat_reg;

endmodule

[hw/rtl/state_space_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// state_space_step: discrete state-space step evaluator
// Loads coefficients of A, B, C and D and computes A*x+B*u and C*x+D*u in
// signed Q8.8 with saturation.
// ----------------------------------------------------------------------------
// After reset the coefficient store is swept to zero, one entry per cycle;
// no input word is accepted until the sweep ends, while count register
// writes are taken at any time. A load word is written to the store when
// the engine takes it from the queue, and gives no result. For an evaluate
// word, every coefficient in use passes one at a time through the single
// coefficient memory read port and the shared multiply-accumulate unit,
// plus pipeline fill and drain; ns, nd and no, the state, drive and output
// counts in use, set how many coefficients that is. An evaluate word with
// no state in use and either no drive or no output in use has nothing to
// compute and gives its all-zero result without a walk, straight from its
// pop off the queue. A two-word queue lets input words be taken while the
// engine is busy or a result waits in the output register.
module state_space_step
    import sss_pkg::*;
#(
    parameter int MAX_STATES  = 4,
    parameter int MAX_DRIVES  = 2,
    parameter int MAX_OUTPUTS = 2,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [1:0]              coef_matrix,
    input  logic [IDX_W-1:0]        coef_row,
    input  logic [IDX_W-1:0]        coef_col,
    input  logic signed [VAL_W-1:0] coef_value,
    input  logic signed [VAL_W-1:0] state_0,
    input  logic signed [VAL_W-1:0] state_1,
    input  logic signed [VAL_W-1:0] state_2,
    input  logic signed [VAL_W-1:0] state_3,
    input  logic signed [VAL_W-1:0] drive_0,
    input  logic signed [VAL_W-1:0] drive_1,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] next_state_0,
    output logic signed [VAL_W-1:0] next_state_1,
    output logic signed [VAL_W-1:0] next_state_2,
    output logic signed [VAL_W-1:0] next_state_3,
    output logic signed [VAL_W-1:0] predicted_0,
    output logic signed [VAL_W-1:0] predicted_1,
    output logic                    saturated
);

    logic                               clearing;
    logic                               q_full;
    logic                               q_empty;
    logic                               push;
    logic                               pop;
    cmd_t                               push_cmd;
    cmd_t                               head;
    logic [NUM_RESULTS-1:0][VAL_W-1:0]  result;

    // Front end: count registers, acceptance and classification.
    sss_front #(
        .MAX_STATES  (MAX_STATES),
        .MAX_DRIVES  (MAX_DRIVES),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .coef_matrix (coef_matrix),
        .coef_row    (coef_row),
        .coef_col    (coef_col),
        .coef_value  (coef_value),
        .state_0     (state_0),
        .state_1     (state_1),
        .state_2     (state_2),
        .state_3     (state_3),
        .drive_0     (drive_0),
        .drive_1     (drive_1),
        .clearing    (clearing),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Command queue between the two sides.
    sss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_full   (q_full),
        .q_empty  (q_empty)
    );

    // Back end: coefficient store and multiply-accumulate engine.
    sss_engine #(
        .MAX_STATES  (MAX_STATES),
        .MAX_DRIVES  (MAX_DRIVES),
        .MAX_OUTPUTS (MAX_OUTPUTS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .saturated (saturated)
    );

    // Result fields.
    assign next_state_0 = $signed(result[0]);
    assign next_state_1 = $signed(result[1]);
    assign next_state_2 = $signed(result[2]);
    assign next_state_3 = $signed(result[3]);
    assign predicted_0  = $signed(result[NUM_STATE_FIELDS]);
    assign predicted_1  = $signed(result[NUM_STATE_FIELDS + 1]);

    // No input word may enter while the store is still being swept.
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !in_ready)
        else $error("input accepted during coefficient store sweep");

    // The engine never takes a command from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_empty)
        else $error("engine popped an empty command queue");

    // Nothing can have been queued by the time the sweep finishes.
    assert property (@(posedge clk) disable iff (!rst_n) $fell(clearing) |-> q_empty)
        else $error("command queued before coefficient store sweep finished");

endmodule

[tb/tb_state_space_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_state_space_step: self-checking bench for the state-space step evaluator
// Streams coefficient loads and evaluate words through random gaps and
// output stalls, predicts every step result from a local copy of the
// coefficient store and of the count registers, and checks each returned
// word field by field. Count registers are rewritten between phases while
// the block is idle, covering zero, in-range and oversized counts.
// ----------------------------------------------------------------------------
module tb_state_space_step;
    import sss_pkg::*;

    // Sizes of the block as instantiated.
    localparam int N_ST  = 4;
    localparam int N_DR  = 2;
    localparam int N_OUT = 2;
    localparam int FRAC  = 8;

    // Layout of the coefficient store: A, B, C, D, each row major.
    localparam int A_BASE     = 0;
    localparam int B_BASE     = A_BASE + N_ST * N_ST;
    localparam int C_BASE     = B_BASE + N_ST * N_DR;
    localparam int D_BASE     = C_BASE + N_OUT * N_ST;
    localparam int COEF_DEPTH = D_BASE + N_OUT * N_DR;

    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 2000;
    localparam int IDLE_PCT      = 8;
    localparam int LOAD_PCT      = 35;

    typedef logic signed [VAL_W-1:0] q88_t;

    typedef struct {
        req_t             kind;
        matrix_t          mat;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        q88_t             value;
        q88_t             x [N_ST];
        q88_t             u [N_DR];
    } word_t;

    typedef struct {
        q88_t nxt [N_ST];
        q88_t pred [N_OUT];
        logic sat;
    } step_out_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic                  req_type     = 1'b0;
    logic [1:0]            coef_matrix  = '0;
    logic [IDX_W-1:0]      coef_row     = '0;
    logic [IDX_W-1:0]      coef_col     = '0;
    q88_t                  coef_value   = '0;
    q88_t                  state_0      = '0;
    q88_t                  state_1      = '0;
    q88_t                  state_2      = '0;
    q88_t                  state_3      = '0;
    q88_t                  drive_0      = '0;
    q88_t                  drive_1      = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    q88_t                  next_state_0;
    q88_t                  next_state_1;
    q88_t                  next_state_2;
    q88_t                  next_state_3;
    q88_t                  predicted_0;
    q88_t                  predicted_1;
    logic                  saturated;

    // Local copy of the block's state and registers.
    q88_t            coef_copy [COEF_DEPTH];
    logic [NS_W-1:0] n_states  = 3'd4;
    logic [ND_W-1:0] n_drives  = 2'd1;
    logic [NO_W-1:0] n_outputs = 2'd2;

    word_t     word_q [$];
    step_out_t step_q [$];
    word_t     cur_word;
    step_out_t want;
    logic      calm = 1'b0;
    int        errors = 0;
    int        quiet_cycles = 0;

    state_space_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .coef_matrix  (coef_matrix),
        .coef_row     (coef_row),
        .coef_col     (coef_col),
        .coef_value   (coef_value),
        .state_0      (state_0),
        .state_1      (state_1),
        .state_2      (state_2),
        .state_3      (state_3),
        .drive_0      (drive_0),
        .drive_1      (drive_1),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .next_state_0 (next_state_0),
        .next_state_1 (next_state_1),
        .next_state_2 (next_state_2),
        .next_state_3 (next_state_3),
        .predicted_0  (predicted_0),
        .predicted_1  (predicted_1),
        .saturated    (saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drop the fraction bits rounding down, then clip to 16 bits.
    function automatic q88_t scale_clip(input longint acc, inout logic clip);
        longint v;
        v = acc >>> FRAC;
        if (v > 32767)
        begin
            v = 32767;
            clip = 1'b1;
        end
        else if (v < -32768)
        begin
            v = -32768;
            clip = 1'b1;
        end
        return v[VAL_W-1:0];
    endfunction

    // Next state A*x+B*u and prediction C*x+D*u over the elements in use.
    function automatic step_out_t compute_step(input word_t w);
        step_out_t r;
        int        ns;
        int        nd;
        int        no;
        longint    acc;
        logic      clip;
        clip = 1'b0;
        ns = (n_states > N_ST) ? N_ST : int'(n_states);
        nd = (n_drives > N_DR) ? N_DR : int'(n_drives);
        no = (n_outputs > N_OUT) ? N_OUT : int'(n_outputs);
        for (int i = 0; i < N_ST; i++)
            r.nxt[i] = '0;
        for (int i = 0; i < N_OUT; i++)
            r.pred[i] = '0;
        for (int i = 0; i < ns; i++)
        begin
            acc = 0;
            for (int j = 0; j < ns; j++)
                acc += longint'(coef_copy[A_BASE + i * N_ST + j]) * longint'(w.x[j]);
            for (int j = 0; j < nd; j++)
                acc += longint'(coef_copy[B_BASE + i * N_DR + j]) * longint'(w.u[j]);
            r.nxt[i] = scale_clip(acc, clip);
        end
        for (int i = 0; i < no; i++)
        begin
            acc = 0;
            for (int j = 0; j < ns; j++)
                acc += longint'(coef_copy[C_BASE + i * N_ST + j]) * longint'(w.x[j]);
            for (int j = 0; j < nd; j++)
                acc += longint'(coef_copy[D_BASE + i * N_DR + j]) * longint'(w.u[j]);
            r.pred[i] = scale_clip(acc, clip);
        end
        r.sat = clip;
        return r;
    endfunction

    // A load lands only if it falls inside the matrix at its largest size.
    function automatic void store_coef(input word_t w);
        int rows;
        int cols;
        int base;
        case (w.mat)
            MAT_A:
            begin
                rows = N_ST;
                cols = N_ST;
                base = A_BASE;
            end
            MAT_B:
            begin
                rows = N_ST;
                cols = N_DR;
                base = B_BASE;
            end
            MAT_C:
            begin
                rows = N_OUT;
                cols = N_ST;
                base = C_BASE;
            end
            default:
            begin
                rows = N_OUT;
                cols = N_DR;
                base = D_BASE;
            end
        endcase
        if (int'(w.row) < rows && int'(w.col) < cols)
            coef_copy[base + int'(w.row) * cols + int'(w.col)] = w.value;
    endfunction

    // Mostly small values, with full-range, extreme and zero values mixed in.
    function automatic q88_t rand_val();
        logic [31:0] raw;
        case ($urandom_range(7))
            0, 1:    raw = $urandom;
            2:       raw = $urandom_range(1) ? 32'h0000_7FFF : 32'h0000_8000;
            3:       raw = '0;
            default: raw = $urandom_range(2048) - 1024;
        endcase
        return raw[VAL_W-1:0];
    endfunction

    function automatic word_t rand_word(input int load_pct);
        word_t       w;
        logic [31:0] raw;
        raw = $urandom;
        w.kind  = (int'($urandom_range(99)) < load_pct) ? REQ_LOAD : REQ_EVAL;
        w.mat   = matrix_t'(raw[1:0]);
        w.row   = raw[3:2];
        w.col   = raw[5:4];
        w.value = rand_val();
        for (int i = 0; i < N_ST; i++)
            w.x[i] = rand_val();
        for (int i = 0; i < N_DR; i++)
            w.u[i] = rand_val();
        return w;
    endfunction

    function automatic word_t load_word(input matrix_t m, input logic [IDX_W-1:0] r,
                                        input logic [IDX_W-1:0] c, input q88_t v);
        word_t w;
        w = rand_word(100);
        w.mat   = m;
        w.row   = r;
        w.col   = c;
        w.value = v;
        return w;
    endfunction

    function automatic word_t eval_word(input q88_t x0, input q88_t x1, input q88_t x2,
                                        input q88_t x3, input q88_t u0, input q88_t u1);
        word_t w;
        w = rand_word(0);
        w.x[0] = x0;
        w.x[1] = x1;
        w.x[2] = x2;
        w.x[3] = x3;
        w.u[0] = u0;
        w.u[1] = u1;
        return w;
    endfunction

    task automatic check_field(input string name, input q88_t exp_v, input q88_t got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // Sender: records each accepted word, then presents the next one or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (cur_word.kind == REQ_LOAD)
                    store_coef(cur_word);
                else
                    step_q.push_back(compute_step(cur_word));
            end
            if (!in_valid || in_ready)
            begin
                if (word_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur_word = word_q.pop_front();
                    req_type    <= cur_word.kind;
                    coef_matrix <= cur_word.mat;
                    coef_row    <= cur_word.row;
                    coef_col    <= cur_word.col;
                    coef_value  <= cur_word.value;
                    state_0     <= cur_word.x[0];
                    state_1     <= cur_word.x[1];
                    state_2     <= cur_word.x[2];
                    state_3     <= cur_word.x[3];
                    drive_0     <= cur_word.u[0];
                    drive_1     <= cur_word.u[1];
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (step_q.size() == 0)
                begin
                    $display("%0t: result word with no step awaited", $time);
                    errors++;
                end
                else
                begin
                    want = step_q.pop_front();
                    check_field("next_state_0", want.nxt[0], next_state_0);
                    check_field("next_state_1", want.nxt[1], next_state_1);
                    check_field("next_state_2", want.nxt[2], next_state_2);
                    check_field("next_state_3", want.nxt[3], next_state_3);
                    check_field("predicted_0", want.pred[0], predicted_0);
                    check_field("predicted_1", want.pred[1], predicted_1);
                    check_field("saturated", {15'd0, want.sat}, {15'd0, saturated});
                end
            end
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: too many cycles in a row with no handshake on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_state_space_step: done, errors");
            $finish;
        end
    end

    // Wait until every word is sent and every step result has come back,
    // then give any trailing loads time to leave the engine.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (word_q.size() != 0 || in_valid || step_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_STATE_COUNT:  n_states  = data;
            CFG_DRIVE_COUNT:  n_drives  = data[ND_W-1:0];
            CFG_OUTPUT_COUNT: n_outputs = data[NO_W-1:0];
            default: ;
        endcase
    endtask

    // One phase: set the counts, then stream random words. With hold set the
    // sender stops halfway until all results are back.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] sc, input logic [CFG_DATA_W-1:0] dc,
                             input logic [CFG_DATA_W-1:0] oc, input int n_words,
                             input logic no_gaps, input logic hold);
        write_cfg(CFG_STATE_COUNT, sc);
        write_cfg(CFG_DRIVE_COUNT, dc);
        write_cfg(CFG_OUTPUT_COUNT, oc);
        @(negedge clk);
        calm = no_gaps;
        for (int k = 0; k < n_words; k++)
        begin
            if (hold && k == n_words / 2)
            begin
                do
                    @(negedge clk);
                while (word_q.size() != 0 || in_valid || step_q.size() != 0);
            end
            word_q.push_back(rand_word(LOAD_PCT));
        end
        wait_idle();
        calm = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < COEF_DEPTH; i++)
            coef_copy[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at the reset counts (4 states, 1 drive, 2 outputs).
        // Extremes against a freshly cleared store give all zeros.
        word_q.push_back(eval_word(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                                   16'sh7FFF, 16'sh8000));
        word_q.push_back(load_word(MAT_A, 2'd0, 2'd0, 16'sh7FFF));
        word_q.push_back(load_word(MAT_A, 2'd0, 2'd1, 16'sh8000));
        word_q.push_back(load_word(MAT_A, 2'd1, 2'd1, 16'sh0100));
        word_q.push_back(load_word(MAT_A, 2'd1, 2'd0, 16'shFFFF));
        word_q.push_back(load_word(MAT_A, 2'd2, 2'd3, 16'shFF00));
        word_q.push_back(load_word(MAT_A, 2'd3, 2'd3, 16'sh0080));
        word_q.push_back(load_word(MAT_B, 2'd0, 2'd0, 16'sh0100));
        // Column beyond the drive count: stored but unused for now.
        word_q.push_back(load_word(MAT_B, 2'd3, 2'd1, 16'sh7FFF));
        // Loads outside the matrix bounds must not alias other entries.
        word_q.push_back(load_word(MAT_B, 2'd1, 2'd2, 16'sh1234));
        word_q.push_back(load_word(MAT_C, 2'd0, 2'd0, 16'sh0100));
        word_q.push_back(load_word(MAT_C, 2'd1, 2'd3, 16'sh8000));
        word_q.push_back(load_word(MAT_C, 2'd2, 2'd0, 16'sh0005));
        word_q.push_back(load_word(MAT_D, 2'd0, 2'd0, 16'sh0200));
        word_q.push_back(load_word(MAT_D, 2'd1, 2'd1, 16'sh7FFF));
        word_q.push_back(load_word(MAT_D, 2'd3, 2'd3, 16'sh004D));
        word_q.push_back(eval_word(16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100,
                                   16'sh0100, 16'sh0100));
        // Clipping high, then clipping low.
        word_q.push_back(eval_word(16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000,
                                   16'sh7FFF, 16'sh7FFF));
        word_q.push_back(eval_word(16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000,
                                   16'sh8000, 16'sh8000));
        // Negative fractions round toward minus infinity.
        word_q.push_back(eval_word(16'sh0000, 16'sh0000, 16'sh0000, 16'shFFFF,
                                   16'sh0000, 16'sh0000));
        word_q.push_back(eval_word(16'sh0001, 16'shFFFF, 16'sh0001, 16'shFFFF,
                                   16'sh0001, 16'shFFFF));
        word_q.push_back(eval_word(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                                   16'sh0000, 16'sh0000));
        wait_idle();

        // Random phases over in-range, zero and oversized counts.
        run_phase(3'd4, 3'd1, 3'd2, 150, 1'b0, 1'b0);
        run_phase(3'd4, 3'd2, 3'd2, 170, 1'b0, 1'b0);
        run_phase(3'd1, 3'd0, 3'd1, 150, 1'b0, 1'b0);
        run_phase(3'd7, 3'd3, 3'd3, 160, 1'b0, 1'b1);
        run_phase(3'd0, 3'd0, 3'd0, 80, 1'b0, 1'b0);
        run_phase(3'd2, 3'd1, 3'd1, 160, 1'b0, 1'b0);
        run_phase(3'd3, 3'd2, 3'd2, 180, 1'b1, 1'b0);
        run_phase(3'd5, 3'd2, 3'd1, 150, 1'b0, 1'b0);
        run_phase(3'd4, 3'd0, 3'd2, 150, 1'b0, 1'b0);
        for (int p = 0; p < 2; p++)
            run_phase(CFG_DATA_W'($urandom_range(7)), CFG_DATA_W'($urandom_range(3)),
                      CFG_DATA_W'($urandom_range(3)), 140, 1'b0, 1'b0);

        if (errors == 0)
            $display("tb_state_space_step: done, clean");
        else
            $display("tb_state_space_step: done, errors");
        $finish;
    end

endmodule
